>>> rtl/lpr_pkg.sv
// Shared types and constants for the IPv4 route table.
package lpr_pkg;
    localparam int unsigned DefDepth = 32;
    localparam int unsigned MaxRes   = 32;

    typedef enum logic [2:0] {
        MODE_UCAST  = 3'd0,
        MODE_MCAST  = 3'd1,
        MODE_ADD    = 3'd2,
        MODE_DEL    = 3'd3,
        MODE_PURGE  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADDEF   = 3'd1,
        ST_OUTSIDE  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_ADD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] host;
        logic [31:0] mask;
        logic [31:0] gw;
        logic [5:0]  iface;
        logic [31:0] metric;
        logic        mc;
    } t_entry;

    // Control from sequencer into every cell.
    typedef struct packed {
        logic        shift;   // cells at or above pos take their upper neighbor
        logic        write;   // cell at pos loads the new entry
        logic [6:0]  pos;
    } t_cell_ctl;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] address;
        logic [31:0] netmask;
        logic [31:0] gateway;
        logic [5:0]  iface;
        logic [31:0] route_metric;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [2:0]  status;
        logic [4:0]  route_index;
        logic [5:0]  out_iface;
        logic [31:0] next_hop;
        logic [31:0] out_metric;
        logic        last;
    } t_rsp;
endpackage

>>> rtl/lpr_if.sv
// Valid/ready channel carrying a packed payload.
interface lpr_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lpr_cell.sv
// One table slot: holds an entry, shifts down on compaction, loads on append.
module lpr_cell (
    input  logic              i_clk,
    input  lpr_pkg::t_cell_ctl i_ctl,
    input  logic [6:0]        i_my_pos,
    input  lpr_pkg::t_entry   i_new,
    input  lpr_pkg::t_entry   i_upper,
    output lpr_pkg::t_entry   o_entry
);
    import lpr_pkg::*;
    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift && i_my_pos >= i_ctl.pos) begin
            r_entry <= i_upper;
        end else if (i_ctl.write && i_my_pos == i_ctl.pos) begin
            r_entry <= i_new;
        end
    end
    assign o_entry = r_entry;
endmodule

>>> rtl/ipv4_longest_prefix_route_table_core.sv
// Top level of the IPv4 route table: a row of entry cells and a scan sequencer.
// One transaction is handled at a time, and the input is ready only while idle.
// Lookups, deletes and purges walk the cell row one entry per cycle while the
// output does not stall. A delete stops at the matching entry. Compaction
// shifts the row in the same cycle that the entry is found. A multicast lookup
// passes through an emit state for each reported match. An add of a specific
// route passes from the scan state to the add state, and an add of a default
// route first scans for an old default. Results go through a one-entry output
// register, and a stalled receiver holds the sequencer.
module ipv4_longest_prefix_route_table_core #(
    parameter int unsigned DEPTH = lpr_pkg::DefDepth
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lpr_if.sink   i_req,
    lpr_if.source o_rsp
);
    import lpr_pkg::*;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] CntOne = CW'(1);

    t_entry    w_ent [DEPTH];
    t_cell_ctl w_ctl;
    t_entry    w_new;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_up;
        if (g == DEPTH - 1) begin : g_top
            assign w_up = w_ent[g];
        end else begin : g_mid
            assign w_up = w_ent[g + 1];
        end
        lpr_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_my_pos(7'(g)),
            .i_new   (w_new),
            .i_upper (w_up),
            .o_entry (w_ent[g])
        );
    end

    t_state       r_state, n_state;
    t_req         r_req;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i;         // scan pointer
    logic [CW-1:0] r_seen, n_seen;   // original position for purge
    logic         r_found, n_found;
    logic [CW-1:0] r_best, n_best;
    logic [5:0]   r_nres, n_nres;
    logic         r_repl, n_repl;
    t_rsp         r_rsp, n_rsp;
    logic         r_ov, n_ov;
    t_entry       w_cur;
    logic         w_match, w_inb, w_push;
    logic [CW-1:0] w_bi;

    assign w_inb  = r_i < r_cnt;
    assign w_cur  = w_ent[r_i[$clog2(DEPTH)-1:0]];
    assign w_match = ((r_req.address ^ w_cur.host) & w_cur.mask) == 32'd0;
    assign w_bi   = r_best;
    assign w_push = !r_ov || o_rsp.ready;

    assign w_new.host   = r_req.address;
    assign w_new.mask   = r_req.netmask;
    assign w_new.gw     = r_req.gateway;
    assign w_new.iface  = r_req.iface;
    assign w_new.metric = r_req.route_metric;
    assign w_new.mc     = r_req.address[31:28] == 4'hE;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_rsp;

    function automatic t_rsp f_rsp(logic hit, t_status st, logic [CW-1:0] idx,
                                   t_entry e, logic use_e, logic last);
        t_rsp r;
        r.hit         = hit;
        r.status      = st;
        r.route_index = 5'(idx);
        r.out_iface   = use_e ? e.iface : 6'd0;
        r.next_hop    = use_e ? e.gw : 32'd0;
        r.out_metric  = use_e ? e.metric : 32'd0;
        r.last        = last;
        return r;
    endfunction

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_SCAN;
            S_SCAN: if (r_ov && !o_rsp.ready) n_state = S_SCAN;
            default: n_state = r_state;
        endcase
        n_cnt = r_cnt; n_i = r_i; n_seen = r_seen; n_found = r_found;
        n_best = r_best; n_nres = r_nres; n_repl = r_repl;
        n_rsp = r_rsp;
        n_ov = r_ov && !o_rsp.ready;
        w_ctl = '0;
        w_ctl.pos = 7'(r_i);
        unique case (r_state)
            S_IDLE: begin
                n_i = '0; n_seen = '0; n_found = 1'b0; n_best = '0;
                n_nres = '0; n_repl = 1'b0;
            end
            S_SCAN: begin
                case (r_req.mode)
                    MODE_UCAST: begin
                        if (w_inb) begin
                            if (!w_cur.mc && w_match &&
                                (!r_found || w_cur.mask > w_ent[w_bi[$clog2(DEPTH)-1:0]].mask))
                                begin
                                n_best = r_i; n_found = 1'b1;
                            end
                            n_i = r_i + CntOne;
                        end else if (w_push) begin
                            n_ov = 1'b1;
                            n_rsp = r_found ?
                                f_rsp(1'b1, ST_OK, r_best,
                                      w_ent[w_bi[$clog2(DEPTH)-1:0]], 1'b1, 1'b1) :
                                f_rsp(1'b0, ST_NOTFOUND, '0, w_cur, 1'b0, 1'b1);
                            n_state = S_IDLE;
                        end
                    end
                    MODE_MCAST: begin
                        if (w_inb && r_nres < 6'(MaxRes)) begin
                            if (w_cur.mc && w_match) begin
                                if (w_push) begin
                                    // a new match shows the held result is not last, so release it
                                    n_state = S_EMIT;
                                    n_best  = r_i;
                                    if (r_found) begin
                                        n_ov  = 1'b1;
                                        n_rsp = r_rsp;
                                    end
                                end
                            end else begin
                                n_i = r_i + CntOne;
                            end
                        end else if (w_push) begin
                            n_ov = 1'b1;
                            n_rsp = r_found ?
                                f_rsp(1'b1, ST_OK, r_best,
                                      w_ent[w_bi[$clog2(DEPTH)-1:0]], 1'b1, 1'b1) :
                                f_rsp(1'b0, ST_NOTFOUND, '0, w_cur, 1'b0, 1'b1);
                            n_state = S_IDLE;
                        end
                    end
                    MODE_ADD: begin
                        if ((r_req.address == 32'd0) != (r_req.netmask == 32'd0)) begin
                            if (w_push) begin
                                n_ov = 1'b1;
                                n_rsp = f_rsp(1'b0, ST_BADDEF, '0, w_cur, 1'b0, 1'b1);
                                n_state = S_IDLE;
                            end
                        end else if ((r_req.address & ~r_req.netmask) != 32'd0) begin
                            if (w_push) begin
                                n_ov = 1'b1;
                                n_rsp = f_rsp(1'b0, ST_OUTSIDE, '0, w_cur, 1'b0, 1'b1);
                                n_state = S_IDLE;
                            end
                        end else if (r_req.netmask == 32'd0 && !r_repl && w_inb) begin
                            if (!w_cur.mc && w_cur.mask == 32'd0) begin
                                w_ctl.shift = 1'b1;
                                n_cnt = r_cnt - CntOne;
                                n_repl = 1'b1;
                            end else begin
                                n_i = r_i + CntOne;
                            end
                        end else begin
                            n_state = S_ADD;
                        end
                    end
                    MODE_DEL: begin
                        if (w_inb) begin
                            if (w_cur.host == r_req.address && w_cur.mask == r_req.netmask &&
                                w_cur.gw == r_req.gateway && w_cur.iface == r_req.iface) begin
                                if (w_push) begin
                                    n_ov = 1'b1;
                                    n_rsp = f_rsp(1'b1, ST_OK, r_i, w_cur, 1'b1, 1'b1);
                                    w_ctl.shift = 1'b1;
                                    n_cnt = r_cnt - CntOne;
                                    n_state = S_IDLE;
                                end
                            end else begin
                                n_i = r_i + CntOne;
                            end
                        end else if (w_push) begin
                            n_ov = 1'b1;
                            n_rsp = f_rsp(1'b0, ST_NOTFOUND, '0, w_cur, 1'b0, 1'b1);
                            n_state = S_IDLE;
                        end
                    end
                    MODE_PURGE: begin
                        if (w_inb) begin
                            if (w_cur.iface == r_req.iface) begin
                                w_ctl.shift = 1'b1;
                                n_cnt = r_cnt - CntOne;
                                if (!r_found) n_best = r_seen;
                                n_found = 1'b1;
                            end else begin
                                n_i = r_i + CntOne;
                            end
                            n_seen = r_seen + CntOne;
                        end else if (w_push) begin
                            n_ov = 1'b1;
                            n_rsp = f_rsp(r_found, r_found ? ST_OK : ST_NOTFOUND,
                                          r_found ? r_best : '0, w_cur, 1'b0, 1'b1);
                            n_rsp.out_iface = r_req.iface;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        if (w_push) begin
                            n_ov = 1'b1;
                            n_rsp = f_rsp(1'b0, ST_NOTFOUND, '0, w_cur, 1'b0, 1'b1);
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_EMIT: begin
                // wait until the previous result has left the output register
                if (w_push) begin
                    n_rsp = f_rsp(1'b1, ST_OK, r_best,
                                  w_ent[w_bi[$clog2(DEPTH)-1:0]], 1'b1, 1'b0);
                    n_found = 1'b1;
                    n_nres = r_nres + 6'd1;
                    n_i = r_i + CntOne;
                    n_state = S_SCAN;
                end
            end
            S_ADD: begin
                if (w_push) begin
                    n_ov = 1'b1;
                    if (r_cnt >= CW'(DEPTH)) begin
                        n_rsp = f_rsp(r_repl, ST_FULL, '0, w_cur, 1'b0, 1'b1);
                    end else begin
                        w_ctl.write = 1'b1;
                        w_ctl.pos = 7'(r_cnt);
                        n_cnt = r_cnt + CntOne;
                        n_rsp = f_rsp(r_repl, ST_OK, r_cnt, w_new, 1'b1, 1'b1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Multicast pending result is held in r_rsp without valid until the next
    // match or the end of the scan decides its last flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_i <= n_i; r_seen <= n_seen; r_found <= n_found; r_best <= n_best;
        r_nres <= n_nres; r_repl <= n_repl; r_rsp <= n_rsp;
        if (i_req.valid && i_req.ready) r_req <= i_req.data;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH)) else $error("entry count over depth");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !o_rsp.ready |=> r_ov && $stable(r_rsp)) else $error("result lost");
    a_nores_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> i_req.ready) else $error("idle not ready");
endmodule
